/* src/lipl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipl_pkg: shared types and constants
// Field widths, register indexes, command codes and the controller/datapath
// command and status bundles of the learned index position lookup.
// ----------------------------------------------------------------------------
package lipl_pkg;

    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_FRAC_BITS    = 32;

    localparam int KEY_W      = 64;
    localparam int COEF_W     = 64;
    localparam int POS_W      = 32;
    localparam int IDX_W      = 10;
    localparam int SEGCNT_W   = 11;
    localparam int ERR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HALF_W     = 32;
    localparam int WIDE_W     = 128;
    localparam int MULCNT_W   = 3;

    // partial products of the 64x64 product, one per cycle
    localparam logic [MULCNT_W-1:0] MUL_STEPS = 3'd4;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEGMENT_COUNT = 3'd0,
        REG_MIN_KEY       = 3'd1,
        REG_MAX_KEY       = 3'd2,
        REG_ENTRY_TOTAL   = 3'd3,
        REG_ERROR_BOUND   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic load;         // write one segment into the tables
        logic init;         // capture key, set search bounds
        logic cmp;          // one binary search compare
        logic mag;          // capture slope magnitude and intercept
        logic mul;          // one partial product step
        logic neg;          // apply slope sign
        logic icpt;         // add intercept
        logic bound;        // form pred - err and pred + err
        logic finish;       // register the computed result
        logic finish_miss;  // register a miss result
    } cmd_t;

    typedef struct packed {
        logic range_miss;
        logic search_done;
        logic mul_last;
    } status_t;

endpackage

/* src/lipl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipl_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lipl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/lipl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipl_ctrl: lookup controller
// Sequences segment loads, and a lookup's range check, binary search, multiply and bound steps.
// ----------------------------------------------------------------------------
module lipl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              command,
    input  lipl_pkg::status_t status,
    output lipl_pkg::cmd_t    cmd,
    output logic              busy
);

    import lipl_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CHECK  = 10'b00_0000_0010,
        ST_PROBE  = 10'b00_0000_0100,
        ST_CMP    = 10'b00_0000_1000,
        ST_MAG    = 10'b00_0001_0000,
        ST_MUL    = 10'b00_0010_0000,
        ST_SIGN   = 10'b00_0100_0000,
        ST_ICPT   = 10'b00_1000_0000,
        ST_BOUND  = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_LOOKUP)
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.range_miss)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // start table is read at mid during this cycle
                state_next = status.search_done ? ST_MAG : ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_PROBE;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (status.mul_last)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                cmd.neg    = 1'b1;
                state_next = ST_ICPT;
            end
            ST_ICPT:
            begin
                cmd.icpt   = 1'b1;
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                cmd.bound  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* src/lipl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipl_dp: lookup datapath
// Configuration registers, segment tables, search bounds, 32x32 multiplier
// with 128-bit accumulator, prediction and range bound logic.
// ----------------------------------------------------------------------------
module lipl_dp #(
    parameter int MAX_SEGMENTS = lipl_pkg::DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = lipl_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lipl_pkg::cmd_t                     cmd,
    output lipl_pkg::status_t                  status,
    input  logic                               cfg_valid,
    input  logic [lipl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lipl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [lipl_pkg::IDX_W-1:0]         seg_index,
    input  logic [lipl_pkg::KEY_W-1:0]         seg_start,
    input  logic signed [lipl_pkg::COEF_W-1:0] seg_slope,
    input  logic signed [lipl_pkg::COEF_W-1:0] seg_intercept,
    input  logic [lipl_pkg::KEY_W-1:0]         key,
    output logic [lipl_pkg::POS_W-1:0]         range_lo,
    output logic [lipl_pkg::POS_W-1:0]         range_hi,
    output logic                               miss,
    output logic                               done
);

    import lipl_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam logic [WIDE_W-1:0] CEIL_ADD = (WIDE_W'(1) << FRAC_BITS) - WIDE_W'(1);

    // configuration
    logic [SEGCNT_W-1:0] segcnt_reg;
    logic [KEY_W-1:0]    min_key_reg;
    logic [KEY_W-1:0]    max_key_reg;
    logic [POS_W-1:0]    total_reg;
    logic [ERR_W-1:0]    err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segcnt_reg  <= SEGCNT_W'(2);
            min_key_reg <= '0;
            max_key_reg <= '0;
            total_reg   <= POS_W'(1);
            err_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEGMENT_COUNT: segcnt_reg  <= cfg_data[SEGCNT_W-1:0];
                REG_MIN_KEY:       min_key_reg <= cfg_data;
                REG_MAX_KEY:       max_key_reg <= cfg_data;
                REG_ENTRY_TOTAL:   total_reg   <= cfg_data[POS_W-1:0];
                REG_ERROR_BOUND:   err_reg     <= cfg_data[ERR_W-1:0];
                default:           ;
            endcase
        end
    end

    // segment tables
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] left_reg;
    logic [AW-1:0] right_reg;
    logic [AW-1:0] mid;
    logic [AW:0]   mid_sum;
    logic [KEY_W-1:0]  start_rdata;
    logic [COEF_W-1:0] slope_rdata;
    logic [COEF_W-1:0] icpt_rdata;

    assign tbl_we    = cmd.load && (32'(seg_index) < 32'(MAX_SEGMENTS));
    assign tbl_waddr = AW'(seg_index);
    assign mid_sum   = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid       = mid_sum[AW:1];

    lipl_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SEGMENTS)) u_start_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (seg_start),
        .raddr (mid),
        .rdata (start_rdata)
    );

    lipl_ram #(.WIDTH(COEF_W), .DEPTH(MAX_SEGMENTS)) u_slope_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (seg_slope),
        .raddr (left_reg),
        .rdata (slope_rdata)
    );

    lipl_ram #(.WIDTH(COEF_W), .DEPTH(MAX_SEGMENTS)) u_icpt_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (seg_intercept),
        .raddr (left_reg),
        .rdata (icpt_rdata)
    );

    // clamp segment count to [2, MAX_SEGMENTS]
    logic [31:0] count_ext;
    logic [31:0] count_clamp;
    logic [31:0] right_init;

    always_comb
    begin
        count_ext = 32'(segcnt_reg);
        if (count_ext < 32'd2)
        begin
            count_clamp = 32'd2;
        end
        else if (count_ext > 32'(MAX_SEGMENTS))
        begin
            count_clamp = 32'(MAX_SEGMENTS);
        end
        else
        begin
            count_clamp = count_ext;
        end
        right_init = count_clamp - 32'd1;
    end

    // search bounds and key
    logic [KEY_W-1:0] key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            key_reg   <= key;
            left_reg  <= '0;
            right_reg <= right_init[AW-1:0];
        end
        else if (cmd.cmp)
        begin
            if (key_reg < start_rdata)
            begin
                right_reg <= mid;
            end
            else
            begin
                left_reg <= mid;
            end
        end
    end

    // multiply: four 32x32 partial products, each registered in pp_reg and accumulated in the next cycle
    logic                  sign_reg;
    logic [COEF_W-1:0]     mag_reg;
    logic [COEF_W-1:0]     icpt_reg;
    logic [MULCNT_W-1:0]   mul_cnt_reg;
    logic [2*HALF_W-1:0]   pp_reg;
    logic [WIDE_W-1:0]     acc_reg;
    logic [HALF_W-1:0]     mul_a;
    logic [HALF_W-1:0]     mul_b;
    logic [WIDE_W-1:0]     pp_shifted;

    always_comb
    begin
        case (mul_cnt_reg)
            3'd0:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = mag_reg[HALF_W-1:0];
            end
            3'd1:
            begin
                mul_a = key_reg[HALF_W-1:0];
                mul_b = mag_reg[2*HALF_W-1:HALF_W];
            end
            3'd2:
            begin
                mul_a = key_reg[2*HALF_W-1:HALF_W];
                mul_b = mag_reg[HALF_W-1:0];
            end
            3'd3:
            begin
                mul_a = key_reg[2*HALF_W-1:HALF_W];
                mul_b = mag_reg[2*HALF_W-1:HALF_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // pp_reg holds the product issued at count - 1
    always_comb
    begin
        case (mul_cnt_reg)
            3'd1:    pp_shifted = WIDE_W'(pp_reg);
            3'd2:    pp_shifted = WIDE_W'(pp_reg) << HALF_W;
            3'd3:    pp_shifted = WIDE_W'(pp_reg) << HALF_W;
            3'd4:    pp_shifted = WIDE_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    assign status.mul_last = (mul_cnt_reg == MUL_STEPS);

    // prediction and bounds
    logic [WIDE_W-1:0] pred_reg;
    logic [WIDE_W-1:0] diff_reg;
    logic [WIDE_W-1:0] hi_reg;
    logic              low_ok_reg;
    logic [WIDE_W-1:0] err_wide;

    assign err_wide = WIDE_W'(err_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.mag)
        begin
            sign_reg    <= slope_rdata[COEF_W-1];
            mag_reg     <= slope_rdata[COEF_W-1] ? (~slope_rdata + COEF_W'(1)) : slope_rdata;
            icpt_reg    <= icpt_rdata;
            mul_cnt_reg <= '0;
            acc_reg     <= '0;
        end
        if (cmd.mul)
        begin
            pp_reg      <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
            acc_reg     <= acc_reg + pp_shifted;
            mul_cnt_reg <= mul_cnt_reg + MULCNT_W'(1);
        end
        if (cmd.neg)
        begin
            pred_reg <= sign_reg ? (~acc_reg + WIDE_W'(1)) : acc_reg;
        end
        if (cmd.icpt)
        begin
            pred_reg <= pred_reg + {{(WIDE_W-COEF_W){icpt_reg[COEF_W-1]}}, icpt_reg};
        end
        if (cmd.bound)
        begin
            low_ok_reg <= !pred_reg[WIDE_W-1] && (pred_reg > err_wide);
            diff_reg   <= pred_reg - err_wide;
            hi_reg     <= pred_reg + err_wide;
        end
    end

    // final bound logic
    logic [KEY_W-1:0]  lower_val;
    logic              lower_ovf;
    logic              res_miss;
    logic              hi_pos;
    logic [WIDE_W-1:0] ceil_val;
    logic [KEY_W-1:0]  upper_full;
    logic              upper_big;
    logic [POS_W-1:0]  upper_val;

    always_comb
    begin
        lower_val  = low_ok_reg ? diff_reg[FRAC_BITS +: KEY_W] : '0;
        lower_ovf  = low_ok_reg && (|diff_reg[WIDE_W-1:KEY_W+FRAC_BITS]);
        res_miss   = lower_ovf || (lower_val >= KEY_W'(total_reg));
        hi_pos     = !hi_reg[WIDE_W-1] && (hi_reg != '0);
        ceil_val   = hi_reg + CEIL_ADD;
        upper_full = ceil_val[FRAC_BITS +: KEY_W];
        upper_big  = |ceil_val[WIDE_W-1:KEY_W+FRAC_BITS];
        if (!hi_pos)
        begin
            upper_val = '0;
        end
        else if (upper_big || (upper_full >= KEY_W'(total_reg)))
        begin
            upper_val = total_reg - POS_W'(1);
        end
        else
        begin
            upper_val = upper_full[POS_W-1:0];
        end
    end

    assign status.range_miss  = (key_reg > max_key_reg) || (key_reg < min_key_reg);
    assign status.search_done = (({1'b0, left_reg} + (AW+1)'(1)) == {1'b0, right_reg});

    // result registers
    logic [POS_W-1:0] lower_reg;
    logic [POS_W-1:0] upper_reg;
    logic             miss_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish || cmd.finish_miss;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_miss || (cmd.finish && res_miss))
        begin
            lower_reg <= total_reg;
            upper_reg <= total_reg;
            miss_reg  <= 1'b1;
        end
        else if (cmd.finish)
        begin
            lower_reg <= lower_val[POS_W-1:0];
            upper_reg <= upper_val;
            miss_reg  <= 1'b0;
        end
    end

    assign range_lo = lower_reg;
    assign range_hi = upper_reg;
    assign miss     = miss_reg;
    assign done     = done_reg;

endmodule

/* src/learned_index_position_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_index_position_lookup: piecewise linear learned index lookup
// A command is taken when start is high and busy is low. A load command
// writes one segment slot, with no result, and leaves busy low. A lookup
// command gives one result, strobed by done for exactly one cycle; the
// receiver cannot stall it. A key outside the configured key range misses
// at the range check, before any search. Otherwise the lookup runs P
// binary search probes (P is about log2 of segment_count - 1, so 10 for a
// 1024-entry table), then the multiply, sign, intercept and bound steps. Each
// probe is a read of the start-key RAM followed by a compare, and the
// prediction takes four partial products through one 32x32 multiplier.
// busy stays high for the whole lookup. Configuration writes are always
// ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module learned_index_position_lookup #(
    parameter int MAX_SEGMENTS = lipl_pkg::DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = lipl_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [lipl_pkg::IDX_W-1:0]         seg_index,
    input  logic [lipl_pkg::KEY_W-1:0]         seg_start,
    input  logic signed [lipl_pkg::COEF_W-1:0] seg_slope,
    input  logic signed [lipl_pkg::COEF_W-1:0] seg_intercept,
    input  logic [lipl_pkg::KEY_W-1:0]         key,
    output logic                               done,
    output logic [lipl_pkg::POS_W-1:0]         range_lo,
    output logic [lipl_pkg::POS_W-1:0]         range_hi,
    output logic                               miss,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lipl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lipl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import lipl_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lipl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    lipl_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .seg_index     (seg_index),
        .seg_start     (seg_start),
        .seg_slope     (seg_slope),
        .seg_intercept (seg_intercept),
        .key           (key),
        .range_lo      (range_lo),
        .range_hi      (range_hi),
        .miss          (miss),
        .done          (done)
    );

endmodule

/* sim/tb_learned_index_position_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_learned_index_position_lookup: self-checking lookup testbench
// Fills the segment tables and sweeps the key range, entry total, error
// bound and segment count registers. Every lookup transaction is predicted
// with exact 128-bit fixed-point arithmetic, and each strobed result is
// checked against the oldest pending position range.
// ----------------------------------------------------------------------------
module tb_learned_index_position_lookup;
    import lipl_pkg::*;

    localparam int NSEG        = DEF_MAX_SEGMENTS;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int CFG_SETTLE  = 8;
    localparam int END_SETTLE  = 64;
    localparam int LOOKUP_GOAL = 350;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [63:0]      st;
        logic [63:0]      sl;
        logic [63:0]      ic;
        logic [63:0]      k;
    } seg_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] lower;
        logic [POS_W-1:0] upper;
        logic             miss;
    } pos_range_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  start         = 1'b0;
    logic                  command       = CMD_LOAD;
    logic [IDX_W-1:0]      seg_index     = '0;
    logic [KEY_W-1:0]      seg_start     = '0;
    logic [COEF_W-1:0]     seg_slope     = '0;
    logic [COEF_W-1:0]     seg_intercept = '0;
    logic [KEY_W-1:0]      key           = '0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  busy;
    logic                  done;
    logic [POS_W-1:0]      range_lo;
    logic [POS_W-1:0]      range_hi;
    logic                  miss;
    logic                  cfg_ready;

    learned_index_position_lookup uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .seg_index     (seg_index),
        .seg_start     (seg_start),
        .seg_slope     (seg_slope),
        .seg_intercept (seg_intercept),
        .key           (key),
        .done          (done),
        .range_lo      (range_lo),
        .range_hi      (range_hi),
        .miss          (miss),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor copy of the segment tables and registers
    logic [63:0]         tbl_start [NSEG];
    logic [63:0]         tbl_slope [NSEG];
    logic [63:0]         tbl_icpt  [NSEG];
    logic [SEGCNT_W-1:0] r_segcnt = 11'd2;
    logic [63:0]         r_min    = '0;
    logic [63:0]         r_max    = '0;
    logic [31:0]         r_total  = 32'd1;
    logic [15:0]         r_err    = '0;

    pos_range_t  range_q [$];
    seg_cmd_t    cmd_q [$];

    // stimulus side bookkeeping
    logic [63:0] gen_start  [NSEG];
    bit          gen_loaded [NSEG];
    logic [63:0] g_lo   = '0;
    logic [63:0] g_span = '0;
    logic [31:0] g_total = 32'd1;

    logic taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   lookups_sent = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] icpt_for(input logic [63:0] st, pos, sl);
        return (pos << FRAC) - st * sl;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got, want);
        fail_count++;
        if (fail_count <= 50)
            $display("mismatch %s: got %0h expected %0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    function automatic pos_range_t predict_range(input logic [63:0] k);
        pos_range_t   res;
        int           cnt;
        int           lo_i;
        int           hi_i;
        int           mid_i;
        logic [63:0]  sl;
        logic [63:0]  mag;
        logic [63:0]  err_q;
        logic [63:0]  lower;
        logic [63:0]  upper;
        logic [63:0]  total;
        logic [127:0] pred;
        logic [127:0] diff;
        logic [127:0] sum_v;
        logic [127:0] rnd;
        total = {32'd0, r_total};
        res.miss = 1'b1;
        res.lower = r_total;
        res.upper = r_total;
        if (k > r_max || k < r_min)
            return res;
        cnt = int'(r_segcnt);
        if (cnt < 2)
            cnt = 2;
        if (cnt > NSEG)
            cnt = NSEG;
        lo_i = 0;
        hi_i = cnt - 1;
        while (lo_i != hi_i - 1)
        begin
            mid_i = (lo_i + hi_i) / 2;
            if (k < tbl_start[mid_i])
                hi_i = mid_i;
            else
                lo_i = mid_i;
        end
        sl = tbl_slope[lo_i];
        mag = sl[63] ? -sl : sl;
        pred = {64'd0, k} * {64'd0, mag};
        if (sl[63])
            pred = -pred;
        pred = pred + {{64{tbl_icpt[lo_i][63]}}, tbl_icpt[lo_i]};
        err_q = {48'd0, r_err} << FRAC;
        // floor of pred - err, zero when not positive
        lower = '0;
        if (!pred[127] && (pred[127:64] != 0 || pred[63:0] > err_q))
        begin
            diff = pred - {64'd0, err_q};
            if (diff[127:64+FRAC] != 0)
                return res;
            lower = diff[64+FRAC-1:FRAC];
        end
        if (lower >= total)
            return res;
        // ceil of pred + err, clamped to the last position
        upper = '0;
        sum_v = pred + {64'd0, err_q};
        if (!sum_v[127] && sum_v != 0)
        begin
            rnd = sum_v + ((128'd1 << FRAC) - 128'd1);
            upper = rnd[64+FRAC-1:FRAC];
            if (rnd[127:64+FRAC] != 0 || upper >= total)
                upper = total - 64'd1;
        end
        res.miss = 1'b0;
        res.lower = lower[31:0];
        res.upper = upper[31:0];
        return res;
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            REG_SEGMENT_COUNT: r_segcnt = data[SEGCNT_W-1:0];
            REG_MIN_KEY:       r_min = data;
            REG_MAX_KEY:       r_max = data;
            REG_ENTRY_TOTAL:   r_total = data[31:0];
            REG_ERROR_BOUND:   r_err = data[15:0];
            default: ;
        endcase
    endtask

    // results are checked and accepted transactions predicted at the rising edge
    always @(posedge clk)
    begin : monitor
        pos_range_t want;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL learned_index_position_lookup");
            $finish;
        end
        else
        begin
            cycle_count++;
            if (rst_n)
            begin
                taken <= start && !busy;
                if (done === 1'b1)
                begin
                    if (range_q.size() == 0)
                        report_mismatch("result with none pending", {range_lo, range_hi}, '0);
                    else
                    begin
                        want = range_q[0];
                        range_q.delete(0);
                        if (range_lo !== want.lower)
                            report_mismatch("range_lo", 64'(range_lo), 64'(want.lower));
                        if (range_hi !== want.upper)
                            report_mismatch("range_hi", 64'(range_hi), 64'(want.upper));
                        if (miss !== want.miss)
                            report_mismatch("miss", 64'(miss), 64'(want.miss));
                    end
                end
                if (cfg_valid && cfg_ready)
                    apply_reg(cfg_index, cfg_data);
                if (start && !busy)
                begin
                    if (command == CMD_LOAD)
                    begin
                        tbl_start[seg_index] = seg_start;
                        tbl_slope[seg_index] = seg_slope;
                        tbl_icpt[seg_index]  = seg_intercept;
                    end
                    else
                        range_q.push_back(predict_range(key));
                end
            end
        end
    end

    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // command driver: holds a transaction until taken, then idles at random
    always @(negedge clk)
    begin : driver
        seg_cmd_t it;
        if (rst_n && !(start && !taken))
        begin
            if (start)
                gap_left = next_gap();
            if (gap_left > 0 || cmd_q.size() == 0)
            begin
                start         <= 1'b0;
                command       <= 1'($urandom);
                seg_index     <= IDX_W'($urandom);
                seg_start     <= rand64();
                seg_slope     <= rand64();
                seg_intercept <= rand64();
                key           <= rand64();
                if (gap_left > 0)
                    gap_left = gap_left - 1;
            end
            else
            begin
                it = cmd_q[0];
                cmd_q.delete(0);
                start         <= 1'b1;
                command       <= it.cmd;
                seg_index     <= it.idx;
                seg_start     <= it.st;
                seg_slope     <= it.sl;
                seg_intercept <= it.ic;
                key           <= it.k;
            end
        end
    end

    task automatic push_load(input int slot, input logic [63:0] st, sl, ic);
        seg_cmd_t it;
        it.cmd = CMD_LOAD;
        it.idx = IDX_W'(slot);
        it.st  = st;
        it.sl  = sl;
        it.ic  = ic;
        it.k   = rand64();
        cmd_q.push_back(it);
        gen_start[slot] = st;
        gen_loaded[slot] = 1'b1;
    endtask

    task automatic push_lookup(input logic [63:0] k);
        seg_cmd_t it;
        it.cmd = CMD_LOOKUP;
        it.idx = IDX_W'($urandom);
        it.st  = rand64();
        it.sl  = rand64();
        it.ic  = rand64();
        it.k   = k;
        cmd_q.push_back(it);
        lookups_sent++;
    endtask

    task automatic wait_drained(input int settle);
        while (cmd_q.size() != 0 || start || range_q.size() != 0 || busy)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_W'($urandom);
        cfg_data  <= rand64();
    endtask

    // unused upper data bits carry junk; the registers keep only their width
    task automatic program_registers(input logic [SEGCNT_W-1:0] raw,
                                     input logic [63:0] mn, mx,
                                     input logic [31:0] total,
                                     input logic [15:0] err);
        logic [63:0] d;
        wait_drained(CFG_SETTLE);
        d = rand64();
        d[SEGCNT_W-1:0] = raw;
        write_reg(REG_SEGMENT_COUNT, d);
        write_reg(REG_MIN_KEY, mn);
        write_reg(REG_MAX_KEY, mx);
        d = rand64();
        d[31:0] = total;
        write_reg(REG_ENTRY_TOTAL, d);
        d = rand64();
        d[15:0] = err;
        write_reg(REG_ERROR_BOUND, d);
        g_total = total;
    endtask

    task automatic random_phase(input int p);
        logic [63:0]         lo;
        logic [63:0]         span;
        logic [63:0]         step;
        logic [63:0]         st;
        logic [63:0]         sl;
        logic [63:0]         ic;
        logic [63:0]         base_sl;
        logic [63:0]         bp;
        logic [63:0]         k;
        logic [63:0]         mn;
        logic [63:0]         mx;
        logic [127:0]        num;
        logic [SEGCNT_W-1:0] raw;
        logic [31:0]         total;
        logic [15:0]         err;
        int                  eff;
        int                  n;
        int                  r;
        int                  i;
        if (p == 2)
            raw = SEGCNT_W'(NSEG);
        else if (p == 3)
            raw = SEGCNT_W'($urandom_range(NSEG + 1, 2047));
        else
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                raw = SEGCNT_W'($urandom_range(0, 1));
            else if (r < 4)
                raw = SEGCNT_W'($urandom_range(17, 80));
            else
                raw = SEGCNT_W'($urandom_range(2, 16));
        end
        eff = (raw < 2) ? 2 : ((raw > NSEG) ? NSEG : raw);

        r = $urandom_range(0, 9);
        if (p == 3)
        begin
            // same table as the full-size phase, count beyond the table
            lo = g_lo;
            span = g_span;
            total = g_total;
        end
        else
        begin
            if (r == 0)
            begin
                lo = '0;
                span = '1;
            end
            else
            begin
                lo = rand64() >> $urandom_range(1, 63);
                if (r == 7)
                    span = 64'($urandom_range(1, 1000));
                else
                    span = rand64() >> $urandom_range(1, 50);
                if (span == 0)
                    span = 1;
                if (lo > ~span)
                    lo = ~span;
            end
            case ($urandom_range(0, 19))
                0:       total = '0;
                1:       total = 32'd1;
                2:       total = '1;
                3, 4, 5: total = $urandom;
                default: total = $urandom_range(2, 65536);
            endcase
        end
        mn = lo;
        mx = lo + span;
        if (r == 8)
        begin
            // inverted key range
            mn = lo + span;
            mx = lo;
        end
        else if (r == 9)
        begin
            mn = lo + span / 4;
            mx = lo + span - span / 4;
        end
        case ($urandom_range(0, 9))
            0:       err = '0;
            1:       err = '1;
            2:       err = 16'($urandom);
            default: err = 16'($urandom_range(0, 64));
        endcase
        g_lo = lo;
        g_span = span;
        program_registers(raw, mn, mx, total, err);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), rand64());

        // sorted segment starts; slopes follow total/span with jitter
        num = ({64'd0, total} << FRAC) / ({64'd0, span} + 128'd1);
        base_sl = (num[127:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : num[63:0];
        step = span / eff;
        for (i = 0; i < eff; i++)
        begin
            if (eff <= 80 || !gen_loaded[i])
            begin
                st = lo + 64'(i) * step + ((step != 0) ? rand64() % step : 64'd0);
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    sl = rand64();
                    ic = rand64();
                end
                else
                begin
                    sl = base_sl - (base_sl >> 3) + rand64() % ((base_sl >> 2) + 1);
                    if (r == 1)
                        sl = -sl;
                    bp = ({32'd0, total} * 64'(i)) / eff;
                    ic = icpt_for(st, bp, sl);
                end
                push_load(i, st, sl, ic);
            end
        end

        n = (eff > 80) ? 60 : $urandom_range(10, 60);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_load($urandom_range(0, NSEG - 1), rand64(), rand64(), rand64());
            else
            begin
                if (r < 64)
                    k = (span == '1) ? rand64() : lo + rand64() % (span + 1);
                else if (r < 76)
                    k = gen_start[$urandom_range(0, eff - 1)] - $urandom_range(0, 1);
                else if (r < 88)
                begin
                    case ($urandom_range(0, 3))
                        0:       k = mn;
                        1:       k = mx;
                        2:       k = mn - 1;
                        default: k = mx + 1;
                    endcase
                end
                else
                    k = rand64();
                push_lookup(k);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] unit;
        int          p;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // three segments and a sentinel, bounds 5 positions either side
        unit = 64'd1 << FRAC;
        program_registers(11'd4, 64'd1000, 64'd1_000_000, 32'd1000, 16'd5);
        push_load(0, 64'd1000, unit, icpt_for(64'd1000, 64'd0, unit));
        push_load(1, 64'd5000, unit >> 1, icpt_for(64'd5000, 64'd200, unit >> 1));
        push_load(2, 64'd100000, -(unit >> 2), icpt_for(64'd100000, 64'd990, -(unit >> 2)));
        push_load(3, '1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        push_lookup(64'd999);         // below min
        push_lookup(64'd1000);        // first start, lower clamps at zero
        push_lookup(64'd1500);
        push_lookup(64'd1990);
        push_lookup(64'd1996);        // upper past end
        push_lookup(64'd4999);        // lower past end
        push_lookup(64'd5001);        // fractional prediction
        push_lookup(64'd99999);
        push_lookup(64'd1_000_000);   // max key, negative prediction
        push_lookup(64'd1_000_001);   // above max

        // count below two, full key range, widest bounds
        program_registers(11'd0, '0, '1, '1, '1);
        push_lookup(64'd0);
        push_lookup(64'd70000);
        push_lookup('1);              // prediction does not fit

        program_registers(11'd4, 64'd1000, 64'd1_000_000, 32'd0, 16'd5);
        push_lookup(64'd1500);        // zero entry total

        program_registers(11'd4, 64'd5000, 64'd10, 32'd1000, 16'd5);
        push_lookup(64'd6000);        // inverted key range
        push_lookup(64'd7);

        p = 0;
        while (lookups_sent < LOOKUP_GOAL || p < 4)
        begin
            random_phase(p);
            p++;
        end

        wait_drained(END_SETTLE);
        if (fail_count == 0 && range_q.size() == 0)
            $display("PASS learned_index_position_lookup");
        else
            $display("FAIL learned_index_position_lookup");
        $finish;
    end

endmodule

/* filelist.f */
src/lipl_pkg.sv
src/lipl_ram.sv
src/lipl_ctrl.sv
src/lipl_dp.sv
src/learned_index_position_lookup.sv
sim/tb_learned_index_position_lookup.sv
